// ===== rtl/framebuffer_filled_circle_raster_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the filled circle raster unit
// Shared wrappers for concurrent assertions reported through $error.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_FILLED_CIRCLE_RASTER_UNIT_ASSERT_SVH
`define FRAMEBUFFER_FILLED_CIRCLE_RASTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Filled circle raster package
// Shared types and command codes for the raster unit and its frame memory.
// ----------------------------------------------------------------------------
package fbcr_pkg;

  // Signed screen coordinate, wide enough for a centre plus or minus a radius.
  localparam int CoordW = 13;
  typedef logic signed [CoordW-1:0] coord_t;

  // Command codes carried by the mode field.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_SPAN,
    ST_STEP,
    ST_READ
  } state_e;

  // Pixel write request, addressed by screen coordinates.
  typedef struct packed {
    logic       en;
    coord_t     col;
    coord_t     row;
    logic [7:0] data;
  } pix_wr_t;

  // Pixel read request, addressed by screen coordinates.
  typedef struct packed {
    logic   en;
    coord_t col;
    coord_t row;
  } pix_rd_t;

endpackage

// ===== rtl/fbcr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Frame memory
// One byte per pixel, stored row by row. Requests carry screen coordinates;
// pixels off the screen are dropped on write and read back as zero.
// ----------------------------------------------------------------------------
module fbcr_frame_mem #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic             clk_i,
  input  fbcr_pkg::pix_wr_t wr_i,
  input  fbcr_pkg::pix_rd_t rd_i,
  output logic [7:0]       rd_data_o
);

  localparam int Pixels = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW  = $clog2(Pixels);
  localparam int ColW   = $clog2(SCREEN_WIDTH);
  localparam int RowW   = $clog2(SCREEN_HEIGHT);

  logic [7:0]       frame_mem [Pixels];
  logic [7:0]       rd_data_q;
  logic             rd_hit_q;
  logic             wr_hit;
  logic             rd_hit;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  // True when a coordinate pair falls on the screen.
  function automatic logic on_screen(fbcr_pkg::coord_t col, fbcr_pkg::coord_t row);
    return (col >= 0) && (row >= 0) &&
           (col < fbcr_pkg::coord_t'(SCREEN_WIDTH)) &&
           (row < fbcr_pkg::coord_t'(SCREEN_HEIGHT));
  endfunction

  // Linear address of an on-screen pixel.
  function automatic logic [AddrW-1:0] pix_addr(fbcr_pkg::coord_t col,
                                                fbcr_pkg::coord_t row);
    logic [AddrW-1:0] row_a;
    logic [AddrW-1:0] col_a;
    row_a = AddrW'(row[RowW-1:0]);
    col_a = AddrW'(col[ColW-1:0]);
    return row_a * AddrW'(SCREEN_WIDTH) + col_a;
  endfunction

  // Clip and address both ports.
  assign wr_hit  = on_screen(wr_i.col, wr_i.row);
  assign rd_hit  = on_screen(rd_i.col, rd_i.row);
  assign wr_addr = pix_addr(wr_i.col, wr_i.row);
  assign rd_addr = pix_addr(rd_i.col, rd_i.row);

  // Memory array with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_hit) begin
      frame_mem[wr_addr] <= wr_i.data;
    end
    if (rd_i.en && rd_hit) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  // Remember whether the last read landed on the screen.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_hit_q <= rd_hit;
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : 8'd0;

endmodule

// ===== rtl/framebuffer_filled_circle_raster_unit.sv =====
// ----------------------------------------------------------------------------
// Filled circle raster unit
// Clears an 8-bit framebuffer, draws filled circles as vertical spans found
// by the midpoint circle walk, and reads single pixels back.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | in_valid_i/in_stall_o   | mode, pos_x, pos_y, radius, paint
//  out     | output    | out_valid_o/out_stall_i | pixel_value (read only)
//
//  A clear writes every pixel, row by row, one pixel write per cycle.
//  A fill runs a setup step for each span, then writes it from top row to bottom row;
//  a walk step follows the center span and each group of four.
//  A read addresses memory on accept, then waits for the output register to free up.
//  Reset clears the sequencer and the output valid bit, not the frame contents.
//  A stalled result holds in the output register while the next command is taken.
//
module framebuffer_filled_circle_raster_unit #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  input  logic [7:0]  radius_i,
  input  logic [7:0]  paint_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_value_o
);

  `include "framebuffer_filled_circle_raster_unit_assert.svh"

  localparam int ColW = $clog2(SCREEN_WIDTH);
  localparam int RowW = $clog2(SCREEN_HEIGHT);

  fbcr_pkg::state_e state_q, state_d;

  fbcr_pkg::coord_t cx_q, cx_d;
  fbcr_pkg::coord_t cy_q, cy_d;
  logic [7:0]       paint_q, paint_d;

  // Midpoint walk state.
  logic [8:0]       walk_col_q, walk_col_d;
  logic [8:0]       walk_row_q, walk_row_d;
  fbcr_pkg::coord_t dec_q, dec_d;
  logic [1:0]       span_sel_q, span_sel_d;
  logic             center_q, center_d;

  // Current span.
  fbcr_pkg::coord_t col_q, col_d;
  fbcr_pkg::coord_t row_q, row_d;
  fbcr_pkg::coord_t bot_q, bot_d;

  // Clear sweep counters.
  logic [ColW-1:0]  clr_col_q, clr_col_d;
  logic [RowW-1:0]  clr_row_q, clr_row_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;

  fbcr_pkg::pix_wr_t wr_req;
  fbcr_pkg::pix_rd_t rd_req;
  logic [7:0]        rd_data;

  logic             in_xfer;
  logic             out_free;
  logic             span_last;
  logic             clr_last;
  logic             walk_more;
  fbcr_pkg::coord_t span_a;
  fbcr_pkg::coord_t span_b;
  fbcr_pkg::coord_t x_pos;
  fbcr_pkg::coord_t y_pos;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign span_last = (row_q == bot_q);
  assign clr_last  = (clr_col_q == ColW'(SCREEN_WIDTH - 1)) &&
                     (clr_row_q == RowW'(SCREEN_HEIGHT - 1));
  assign walk_more = (walk_col_q < walk_row_q);
  assign x_pos     = fbcr_pkg::coord_t'(pos_x_i);
  assign y_pos     = fbcr_pkg::coord_t'(pos_y_i);

  // Span offsets: even spans step the column by the walk column, odd ones by
  // the walk row; the upper select bit mirrors the span to the left.
  assign span_a = span_sel_q[0] ? fbcr_pkg::coord_t'(walk_row_q)
                                : fbcr_pkg::coord_t'(walk_col_q);
  assign span_b = span_sel_q[0] ? fbcr_pkg::coord_t'(walk_col_q)
                                : fbcr_pkg::coord_t'(walk_row_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbcr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (mode_i)
            fbcr_pkg::MODE_CLEAR: state_d = fbcr_pkg::ST_CLEAR;
            fbcr_pkg::MODE_FILL:  state_d = fbcr_pkg::ST_SETUP;
            fbcr_pkg::MODE_READ:  state_d = fbcr_pkg::ST_READ;
            default:              state_d = fbcr_pkg::ST_IDLE;
          endcase
        end
      end
      fbcr_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = fbcr_pkg::ST_IDLE;
        end
      end
      fbcr_pkg::ST_SETUP: state_d = fbcr_pkg::ST_SPAN;
      fbcr_pkg::ST_SPAN: begin
        if (span_last) begin
          state_d = (center_q || (span_sel_q == 2'd3)) ? fbcr_pkg::ST_STEP
                                                        : fbcr_pkg::ST_SETUP;
        end
      end
      fbcr_pkg::ST_STEP: begin
        state_d = walk_more ? fbcr_pkg::ST_SETUP : fbcr_pkg::ST_IDLE;
      end
      fbcr_pkg::ST_READ: begin
        if (out_free) begin
          state_d = fbcr_pkg::ST_IDLE;
        end
      end
      default: state_d = fbcr_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory requests and output register loading.
  always_comb begin
    cx_d        = cx_q;
    cy_d        = cy_q;
    paint_d     = paint_q;
    walk_col_d  = walk_col_q;
    walk_row_d  = walk_row_q;
    dec_d       = dec_q;
    span_sel_d  = span_sel_q;
    center_d    = center_q;
    col_d       = col_q;
    row_d       = row_q;
    bot_d       = bot_q;
    clr_col_d   = clr_col_q;
    clr_row_d   = clr_row_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    wr_req      = '0;
    wr_req.data = paint_q;
    rd_req      = '0;
    rd_req.col  = x_pos;
    rd_req.row  = y_pos;

    case (state_q)
      fbcr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cx_d       = x_pos;
          cy_d       = y_pos;
          paint_d    = paint_i;
          clr_col_d  = '0;
          clr_row_d  = '0;
          // The walk starts at the top of the circle with the centre column.
          if (mode_i == fbcr_pkg::MODE_FILL) begin
            walk_col_d = '0;
            walk_row_d = 9'(radius_i);
            dec_d      = fbcr_pkg::coord_t'(1) - fbcr_pkg::coord_t'(radius_i);
            span_sel_d = '0;
            center_d   = 1'b1;
          end
          rd_req.en  = (mode_i == fbcr_pkg::MODE_READ);
        end
      end
      fbcr_pkg::ST_CLEAR: begin
        wr_req.en  = 1'b1;
        wr_req.col = fbcr_pkg::coord_t'(clr_col_q);
        wr_req.row = fbcr_pkg::coord_t'(clr_row_q);
        if (clr_col_q == ColW'(SCREEN_WIDTH - 1)) begin
          clr_col_d = '0;
          clr_row_d = clr_row_q + 1'b1;
        end else begin
          clr_col_d = clr_col_q + 1'b1;
        end
      end
      fbcr_pkg::ST_SETUP: begin
        col_d = span_sel_q[1] ? (cx_q - span_a) : (cx_q + span_a);
        row_d = cy_q - span_b;
        bot_d = cy_q + span_b;
      end
      fbcr_pkg::ST_SPAN: begin
        wr_req.en  = 1'b1;
        wr_req.col = col_q;
        wr_req.row = row_q;
        row_d      = row_q + fbcr_pkg::coord_t'(1);
        if (span_last) begin
          center_d   = 1'b0;
          span_sel_d = center_q ? span_sel_q : span_sel_q + 2'd1;
        end
      end
      fbcr_pkg::ST_STEP: begin
        // One midpoint step: the row offset drops when the decision term is
        // not negative, then the column offset advances.
        if (walk_more) begin
          span_sel_d = '0;
          walk_col_d = walk_col_q + 9'd1;
          if (dec_q >= 0) begin
            walk_row_d = walk_row_q - 9'd1;
            dec_d = dec_q + fbcr_pkg::coord_t'({walk_col_q, 1'b1}) + fbcr_pkg::coord_t'(2)
                    - fbcr_pkg::coord_t'({walk_row_q, 1'b0}) + fbcr_pkg::coord_t'(2);
          end else begin
            dec_d = dec_q + fbcr_pkg::coord_t'({walk_col_q, 1'b1}) + fbcr_pkg::coord_t'(2);
          end
        end
      end
      fbcr_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbcr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      walk_col_q  <= '0;
      walk_row_q  <= '0;
      dec_q       <= '0;
      span_sel_q  <= '0;
      center_q    <= 1'b0;
      clr_col_q   <= '0;
      clr_row_q   <= '0;
      row_q       <= '0;
      bot_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      walk_col_q  <= walk_col_d;
      walk_row_q  <= walk_row_d;
      dec_q       <= dec_d;
      span_sel_q  <= span_sel_d;
      center_q    <= center_d;
      clr_col_q   <= clr_col_d;
      clr_row_q   <= clr_row_d;
      row_q       <= row_d;
      bot_q       <= bot_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    paint_q    <= paint_d;
    col_q      <= col_d;
    out_data_q <= out_data_d;
  end

  fbcr_frame_mem #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_frame_mem (
    .clk_i    (clk_i),
    .wr_i     (wr_req),
    .rd_i     (rd_req),
    .rd_data_o(rd_data)
  );

  assign in_stall_o    = (state_q != fbcr_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_data_q;

  // A span never runs past its bottom row.
  `FBCR_ASSERT_IMPL(a_span_bounded, clk_i, rst_ni, state_q == fbcr_pkg::ST_SPAN,
                    row_q <= bot_q, "span row passed its bottom row")
  // A fill command starts with span setup.
  `FBCR_ASSERT_NEXT(a_fill_start, clk_i, rst_ni,
                    in_xfer && (mode_i == fbcr_pkg::MODE_FILL),
                    state_q == fbcr_pkg::ST_SETUP, "fill did not start with span setup")
  // A read that finds the output register free leaves a result behind.
  `FBCR_ASSERT_NEXT(a_read_result, clk_i, rst_ni,
                    (state_q == fbcr_pkg::ST_READ) && out_free,
                    out_valid_q, "read finished without a result")
  // The walk column never gets more than one past the walk row.
  `FBCR_ASSERT_IMPL(a_walk_order, clk_i, rst_ni, 1'b1,
                    {1'b0, walk_col_q} <= ({1'b0, walk_row_q} + 10'd1),
                    "midpoint walk went past the diagonal")

endmodule

// ===== verif/tb_framebuffer_filled_circle_raster_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the filled circle raster unit
// Drives clear, fill-circle, read and unused-mode commands through the valid/stall
// input channel and keeps a shadow framebuffer that replays every accepted command.
// Each read transfer on the output channel is checked against the shadow
// pixel. The input channel idles and the output channel stalls at random.
// ----------------------------------------------------------------------------
module tb_framebuffer_filled_circle_raster_unit;

  localparam int SCREEN_W = 240;
  localparam int SCREEN_H = 240;
  localparam int FRAME_SIZE = SCREEN_W * SCREEN_H;
  localparam int RANDOM_CMDS = 1425;
  // A radius-255 fill makes no transfer at all until it finishes.
  localparam int IDLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        mode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]        radius;
    logic [7:0]        paint;
    bit                drain;
  } raster_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = fbcr_pkg::MODE_CLEAR;
  logic signed [11:0] pos_x_i = '0;
  logic signed [11:0] pos_y_i = '0;
  logic [7:0] radius_i = '0;
  logic [7:0] paint_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] pixel_value_o;

  // Shadow copy of the frame and of the walk registers.
  logic [7:0] frame_mem [0:FRAME_SIZE-1];
  logic [8:0] walk_col = '0;
  logic [8:0] walk_row = '0;
  logic [11:0] decision_term = '0;
  logic [11:0] span_row = '0;

  raster_cmd_t raster_cmd_q [$];
  logic [7:0] pixel_readback_q [$];

  int total_cmds = 0;
  int accepted_cnt = 0;
  int fail_cnt = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  int stall_tick = 0;

  framebuffer_filled_circle_raster_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .radius_i     (radius_i),
    .paint_i      (paint_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_value_o(pixel_value_o)
  );

  always #6 clk_i = ~clk_i;

  // One vertical span, both end rows included, clipped to the screen.
  task automatic draw_column_span(int col, int top, int len, logic [7:0] color);
    int row;
    row = top;
    do begin
      span_row = row[11:0];
      if (col >= 0 && row >= 0 && col < SCREEN_W && row < SCREEN_H) begin
        frame_mem[row * SCREEN_W + col] = color;
      end
      row++;
    end while (top + len >= row);
  endtask

  // Midpoint circle walk: centre column first, then four mirrored spans per step.
  task automatic draw_filled_circle(int cx, int cy, int rad, logic [7:0] color);
    int decide;
    int step_col;
    int step_row;
    int dx;
    int dy;
    decide = 1 - rad;
    step_col = 1;
    step_row = -2 * rad;
    dx = 0;
    dy = rad;
    draw_column_span(cx, cy - rad, 2 * rad, color);
    while (dx < dy) begin
      if (decide >= 0) begin
        dy--;
        step_row += 2;
        decide += step_row;
      end
      dx++;
      step_col += 2;
      decide += step_col;
      draw_column_span(cx + dx, cy - dy, 2 * dy, color);
      draw_column_span(cx + dy, cy - dx, 2 * dx, color);
      draw_column_span(cx - dx, cy - dy, 2 * dy, color);
      draw_column_span(cx - dy, cy - dx, 2 * dx, color);
    end
    walk_col = dx[8:0];
    walk_row = dy[8:0];
    decision_term = decide[11:0];
  endtask

  // Replays one accepted command on the shadow frame; reads queue their pixel.
  task automatic apply_raster_cmd(raster_cmd_t cmd);
    int col;
    int row;
    col = int'(cmd.pos_x);
    row = int'(cmd.pos_y);
    case (cmd.mode)
      fbcr_pkg::MODE_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = cmd.paint;
      end
      fbcr_pkg::MODE_FILL: begin
        draw_filled_circle(col, row, int'(cmd.radius), cmd.paint);
      end
      fbcr_pkg::MODE_READ: begin
        if (col >= 0 && row >= 0 && col < SCREEN_W && row < SCREEN_H) begin
          pixel_readback_q.push_back(frame_mem[row * SCREEN_W + col]);
        end else begin
          pixel_readback_q.push_back(8'h00);
        end
      end
      default: begin
        // The unused mode is dropped without any effect.
      end
    endcase
  endtask

  task automatic push_cmd(logic [1:0] mode, int px, int py, int rad, int color, bit drain);
    raster_cmd_t cmd;
    cmd.mode = mode;
    cmd.pos_x = 12'(px);
    cmd.pos_y = 12'(py);
    cmd.radius = 8'(rad);
    cmd.paint = 8'(color);
    cmd.drain = drain;
    raster_cmd_q.push_back(cmd);
    total_cmds++;
  endtask

  // Sender: bursts of transfers with random gaps; a drain item waits for all reads.
  always @(negedge clk_i) begin : sender
    raster_cmd_t cmd;
    logic show;
    show = 1'b0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (raster_cmd_q.size() > 0 &&
                   !(raster_cmd_q[0].drain && pixel_readback_q.size() != 0)) begin
        cmd = raster_cmd_q.pop_front();
        show = 1'b1;
        mode_i <= cmd.mode;
        pos_x_i <= cmd.pos_x;
        pos_y_i <= cmd.pos_y;
        radius_i <= cmd.radius;
        paint_i <= cmd.paint;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid_i <= show;
    end
  end

  // Receiver: bits 10:9 of a tick counter pick the stall pattern.
  always @(negedge clk_i) begin : receiver
    stall_tick++;
    case (stall_tick[10:9])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= 1'($urandom_range(0, 1));
      2'd2: out_stall_i <= (stall_tick % 7) < 4;
      default: out_stall_i <= $urandom_range(0, 9) < 8;
    endcase
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk_i) begin : monitor
    raster_cmd_t cmd;
    logic [7:0] want;
    logic busy;
    busy = 1'b0;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cmd.mode = mode_i;
        cmd.pos_x = pos_x_i;
        cmd.pos_y = pos_y_i;
        cmd.radius = radius_i;
        cmd.paint = paint_i;
        cmd.drain = 1'b0;
        apply_raster_cmd(cmd);
        accepted_cnt++;
        busy = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        if (pixel_readback_q.size() == 0) begin
          $error("pixel_value: expected no transfer, actual %0d", pixel_value_o);
          fail_cnt++;
        end else begin
          want = pixel_readback_q.pop_front();
          if (pixel_value_o !== want) begin
            $error("pixel_value: expected %0d, actual %0d", want, pixel_value_o);
            fail_cnt++;
          end
        end
      end
      // Watchdog on cycles without any transfer.
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int counted;
    int pick;
    int ring_x;
    int ring_y;
    int ring_r;
    int rad;
    int cx;
    int cy;
    counted = 0;
    ring_x = 120;
    ring_y = 120;
    ring_r = 8;

    // Directed part: the frame is cleared first so that every pixel is defined.
    push_cmd(fbcr_pkg::MODE_CLEAR, 0, 0, 0, 8'h00, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 0, 0, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 239, 239, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_FILL, 10, 10, 0, 8'hFF, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 10, 10, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 11, 10, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_FILL, -1, 5, 0, 8'h77, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 0, 5, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_FILL, 0, 0, 5, 8'hA5, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 0, 5, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 5, 1, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_FILL, 239, 239, 3, 8'h3C, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 237, 238, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, -1, 0, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 240, 0, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 0, 240, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, -2048, 2047, 0, 0, 1'b0);
    push_cmd(MODE_UNUSED, 2047, -2048, 255, 8'hFF, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 10, 10, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_FILL, 120, 120, 255, 8'h81, 1'b1);
    push_cmd(fbcr_pkg::MODE_READ, 239, 0, 0, 0, 1'b0);
    push_cmd(fbcr_pkg::MODE_CLEAR, 0, 0, 0, 8'hFF, 1'b1);
    push_cmd(fbcr_pkg::MODE_FILL, -2048, -2048, 128, 8'h00, 1'b0);
    push_cmd(fbcr_pkg::MODE_READ, 100, 100, 0, 0, 1'b0);

    // Random part: mostly small circles with reads around the latest one.
    while (counted < RANDOM_CMDS) begin
      pick = $urandom_range(0, 999);
      if (pick < 2) begin
        push_cmd(fbcr_pkg::MODE_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
        counted++;
      end else if (pick < 420) begin
        pick = $urandom_range(0, 99);
        rad = (pick < 6) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if (pick >= 95) begin
          cx = int'($urandom_range(0, 4095)) - 2048;
          cy = int'($urandom_range(0, 4095)) - 2048;
        end else begin
          cx = int'($urandom_range(0, 279)) - 20;
          cy = int'($urandom_range(0, 279)) - 20;
        end
        ring_x = cx;
        ring_y = cy;
        ring_r = rad;
        push_cmd(fbcr_pkg::MODE_FILL, cx, cy, rad, $urandom_range(0, 255),
                 $urandom_range(0, 49) == 0);
        counted++;
      end else if (pick < 990) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          cx = ring_x + int'($urandom_range(0, 2 * ring_r + 4)) - (ring_r + 2);
          cy = ring_y + int'($urandom_range(0, 2 * ring_r + 4)) - (ring_r + 2);
        end else if (pick < 9) begin
          cx = $urandom_range(0, SCREEN_W - 1);
          cy = $urandom_range(0, SCREEN_H - 1);
        end else begin
          cx = int'($urandom_range(0, 4095)) - 2048;
          cy = int'($urandom_range(0, 4095)) - 2048;
        end
        push_cmd(fbcr_pkg::MODE_READ, cx, cy, $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 49) == 0);
        counted++;
      end else begin
        push_cmd(MODE_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      end
    end
    // A closing read proves that every earlier command has finished.
    push_cmd(fbcr_pkg::MODE_READ, 120, 120, 0, 0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_cnt == total_cmds && pixel_readback_q.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
